// ===== hw/rtl/nhpw_pkg.sv =====
// Shared constants and types for the net half-perimeter wirelength core.
package nhpw_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int LEN_W          = 23;
  localparam int TOTAL_W        = 48;
  localparam int SCALE_W        = 24;
  localparam int SCALE_FRAC     = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [LEN_W-1:0]   LEN_MAX     = {LEN_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAD_SCALE_X = 1'b0,
    CFG_PAD_SCALE_Y = 1'b1
  } cfg_reg_t;

  // Per-pin control bits carried down the pipeline
  typedef struct packed {
    logic last;
    logic clr;
  } pin_flags_t;

endpackage

// ===== hw/rtl/nhpw_if.sv =====
// Valid/ready channel interfaces for pin beats and net result beats.
interface nhpw_pin_if #(
  parameter int COORD_BITS = nhpw_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pin_x;
  logic [COORD_BITS-1:0] pin_y;
  logic [COORD_BITS-1:0] module_x;
  logic [COORD_BITS-1:0] module_y;
  logic [COORD_BITS-1:0] module_width;
  logic                  rotated;
  logic                  is_pad;
  logic                  last_in_net;
  logic                  clear_total;

  modport source (
    output valid, pin_x, pin_y, module_x, module_y, module_width,
           rotated, is_pad, last_in_net, clear_total,
    input  ready
  );
  modport sink (
    input  valid, pin_x, pin_y, module_x, module_y, module_width,
           rotated, is_pad, last_in_net, clear_total,
    output ready
  );
endinterface

interface nhpw_res_if;
  logic                          valid;
  logic                          ready;
  logic [nhpw_pkg::LEN_W-1:0]    net_length;
  logic [nhpw_pkg::TOTAL_W-1:0]  total_length;
  logic                          total_saturated;

  modport source (
    output valid, net_length, total_length, total_saturated,
    input  ready
  );
  modport sink (
    input  valid, net_length, total_length, total_saturated,
    output ready
  );
endinterface

// ===== hw/rtl/net_half_perimeter_wirelength_core.sv =====
// Top level: pin transform, bounding box, length and saturating total pipeline.
// A net's result follows its final pin beat through the a, b, c, d and result registers.
// Throughput: one pin beat per cycle when the output does not stall, set by the box
// compare-update and 48-bit total add loops; output stalls back up the stage registers.
// Reset (synchronous, rst_n low): stages empty, box empty, total and flag zero,
// pad scales 1.0. No clearing pass is needed.
module net_half_perimeter_wirelength_core #(
  parameter int COORD_BITS = nhpw_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nhpw_pin_if.sink                        in_pin,
  nhpw_res_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [nhpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nhpw_pkg::SCALE_W-1:0]    cfg_wdata
);

  localparam int POS_W = COORD_BITS + 2;

  logic                       pos_valid, pos_ready;
  logic [POS_W-1:0]           pos_x, pos_y;
  nhpw_pkg::pin_flags_t       pos_flags;
  logic                       len_valid, len_ready, len_clr;
  logic [nhpw_pkg::LEN_W-1:0] len_value;

  nhpw_pos #(
    .COORD_BITS (COORD_BITS),
    .POS_W      (POS_W)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pin    (in_pin),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_flags (pos_flags)
  );

  nhpw_box #(
    .POS_W (POS_W)
  ) u_box (
    .clk       (clk),
    .rst_n     (rst_n),
    .pos_valid (pos_valid),
    .pos_ready (pos_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_flags (pos_flags),
    .len_valid (len_valid),
    .len_ready (len_ready),
    .len_value (len_value),
    .len_clr   (len_clr)
  );

  nhpw_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .len_valid (len_valid),
    .len_ready (len_ready),
    .len_value (len_value),
    .len_clr   (len_clr),
    .out_res   (out_res)
  );

endmodule

// ===== hw/rtl/nhpw_pos.sv =====
// Input register, pad scale registers and pin position transform stage.
module nhpw_pos #(
  parameter int COORD_BITS = nhpw_pkg::COORD_BITS_DEF,
  parameter int POS_W      = COORD_BITS + 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  nhpw_pin_if.sink                          in_pin,
  input  logic                              cfg_we,
  input  logic [nhpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nhpw_pkg::SCALE_W-1:0]      cfg_wdata,
  output logic                              pos_valid,
  input  logic                              pos_ready,
  output logic [POS_W-1:0]                  pos_x,
  output logic [POS_W-1:0]                  pos_y,
  output nhpw_pkg::pin_flags_t              pos_flags
);

  localparam int PROD_W = COORD_BITS + nhpw_pkg::SCALE_W;
  localparam int SHR_W  = PROD_W - nhpw_pkg::SCALE_FRAC;

  logic [nhpw_pkg::SCALE_W-1:0] scale_x_r, scale_y_r;

  logic                  a_valid_r;
  logic [COORD_BITS-1:0] a_px_r, a_py_r, a_mx_r, a_my_r, a_mw_r;
  logic                  a_rot_r, a_pad_r;
  nhpw_pkg::pin_flags_t  a_flags_r;

  logic                  b_valid_r;
  logic [POS_W-1:0]      b_x_r, b_y_r;
  nhpw_pkg::pin_flags_t  b_flags_r;

  logic en_a, en_b;

  logic [PROD_W-1:0]     prod_x, prod_y;
  logic [SHR_W-1:0]      shr_x, shr_y;
  logic [POS_W-1:0]      pad_x, pad_y;
  logic [COORD_BITS:0]   sum_x, sum_y, up_y, rot_y;
  logic [POS_W-1:0]      x_nxt, y_nxt;

  // Advance a stage when it is empty or its contents move on
  assign en_b         = !b_valid_r || pos_ready;
  assign en_a         = !a_valid_r || en_b;
  assign in_pin.ready = en_a;

  // Pad scale registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= nhpw_pkg::SCALE_RESET;
      scale_y_r <= nhpw_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (nhpw_pkg::cfg_reg_t'(cfg_index))
        nhpw_pkg::CFG_PAD_SCALE_X: scale_x_r <= cfg_wdata;
        nhpw_pkg::CFG_PAD_SCALE_Y: scale_y_r <= cfg_wdata;
      endcase
    end
  end

  // Capture the incoming pin beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= in_pin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_pin.valid) begin
      a_px_r          <= in_pin.pin_x;
      a_py_r          <= in_pin.pin_y;
      a_mx_r          <= in_pin.module_x;
      a_my_r          <= in_pin.module_y;
      a_mw_r          <= in_pin.module_width;
      a_rot_r         <= in_pin.rotated;
      a_pad_r         <= in_pin.is_pad;
      a_flags_r.last  <= in_pin.last_in_net;
      a_flags_r.clr   <= in_pin.clear_total;
    end
  end

  // Scale pad coordinates, truncate, clamp to the position range
  always_comb begin
    prod_x = PROD_W'(a_px_r) * PROD_W'(scale_x_r);
    prod_y = PROD_W'(a_py_r) * PROD_W'(scale_y_r);
    shr_x  = prod_x[PROD_W-1:nhpw_pkg::SCALE_FRAC];
    shr_y  = prod_y[PROD_W-1:nhpw_pkg::SCALE_FRAC];
    pad_x  = (|shr_x[SHR_W-1:POS_W]) ? {POS_W{1'b1}} : shr_x[POS_W-1:0];
    pad_y  = (|shr_y[SHR_W-1:POS_W]) ? {POS_W{1'b1}} : shr_y[POS_W-1:0];
  end

  // Module pin: offset plus origin, swapped and mirrored when rotated
  always_comb begin
    sum_x = {1'b0, a_mx_r} + {1'b0, a_rot_r ? a_py_r : a_px_r};
    sum_y = {1'b0, a_my_r} + {1'b0, a_py_r};
    up_y  = {1'b0, a_my_r} + {1'b0, a_mw_r};
    rot_y = (up_y >= {1'b0, a_px_r}) ? (up_y - {1'b0, a_px_r}) : '0;
    if (a_pad_r) begin
      x_nxt = pad_x;
      y_nxt = pad_y;
    end else begin
      x_nxt = POS_W'(sum_x);
      y_nxt = a_rot_r ? POS_W'(rot_y) : POS_W'(sum_y);
    end
  end

  // Hold the absolute position for the box stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid_r) begin
      b_x_r     <= x_nxt;
      b_y_r     <= y_nxt;
      b_flags_r <= a_flags_r;
    end
  end

  assign pos_valid = b_valid_r;
  assign pos_x     = b_x_r;
  assign pos_y     = b_y_r;
  assign pos_flags = b_flags_r;

endmodule

// ===== hw/rtl/nhpw_box.sv =====
// Running bounding box of the current net and half-perimeter stage.
module nhpw_box #(
  parameter int POS_W = nhpw_pkg::COORD_BITS_DEF + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pos_valid,
  output logic                        pos_ready,
  input  logic [POS_W-1:0]            pos_x,
  input  logic [POS_W-1:0]            pos_y,
  input  nhpw_pkg::pin_flags_t        pos_flags,
  output logic                        len_valid,
  input  logic                        len_ready,
  output logic [nhpw_pkg::LEN_W-1:0]  len_value,
  output logic                        len_clr
);

  localparam int SUM_W = (POS_W + 1 > nhpw_pkg::LEN_W) ? POS_W + 1 : nhpw_pkg::LEN_W + 1;

  logic [POS_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [POS_W-1:0] min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;

  logic             c_valid_r, c_clr_r;
  logic [POS_W-1:0] c_min_x_r, c_max_x_r, c_min_y_r, c_max_y_r;

  logic                       d_valid_r, d_clr_r;
  logic [nhpw_pkg::LEN_W-1:0] d_len_r;

  logic             en_c, en_d, fire;
  logic [POS_W-1:0] dx, dy;
  logic [SUM_W-1:0] len_sum;
  logic [nhpw_pkg::LEN_W-1:0] len_nxt;

  assign en_d      = !d_valid_r || len_ready;
  assign en_c      = !c_valid_r || en_d;
  assign pos_ready = en_c;
  assign fire      = pos_valid && en_c;

  // Fold the new pin into the box
  always_comb begin
    min_x_nxt = (pos_x < min_x_r) ? pos_x : min_x_r;
    max_x_nxt = (pos_x > max_x_r) ? pos_x : max_x_r;
    min_y_nxt = (pos_y < min_y_r) ? pos_y : min_y_r;
    max_y_nxt = (pos_y > max_y_r) ? pos_y : max_y_r;
  end

  // Update the box; empty it after the final pin of a net
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && pos_flags.last)) begin
      min_x_r <= {POS_W{1'b1}};
      min_y_r <= {POS_W{1'b1}};
      max_x_r <= '0;
      max_y_r <= '0;
    end else if (fire) begin
      min_x_r <= min_x_nxt;
      min_y_r <= min_y_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
    end
  end

  // Latch the finished box of a net
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en_c) begin
      c_valid_r <= pos_valid && pos_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pos_flags.last) begin
      c_min_x_r <= min_x_nxt;
      c_max_x_r <= max_x_nxt;
      c_min_y_r <= min_y_nxt;
      c_max_y_r <= max_y_nxt;
      c_clr_r   <= pos_flags.clr;
    end
  end

  // Width plus height, clamped to the length range
  always_comb begin
    dx      = c_max_x_r - c_min_x_r;
    dy      = c_max_y_r - c_min_y_r;
    len_sum = SUM_W'(dx) + SUM_W'(dy);
    len_nxt = (len_sum > SUM_W'(nhpw_pkg::LEN_MAX)) ? nhpw_pkg::LEN_MAX
                                                   : len_sum[nhpw_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en_d) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_valid_r) begin
      d_len_r <= len_nxt;
      d_clr_r <= c_clr_r;
    end
  end

  assign len_valid = d_valid_r;
  assign len_value = d_len_r;
  assign len_clr   = d_clr_r;

endmodule

// ===== hw/rtl/nhpw_acc.sv =====
// Saturating running total of net lengths and the result register.
module nhpw_acc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        len_valid,
  output logic                        len_ready,
  input  logic [nhpw_pkg::LEN_W-1:0]  len_value,
  input  logic                        len_clr,
  nhpw_res_if.source                  out_res
);

  localparam int TW = nhpw_pkg::TOTAL_W;

  logic [TW-1:0]              total_r;
  logic                       sat_r;
  logic                       out_valid_r;
  logic [nhpw_pkg::LEN_W-1:0] out_len_r;

  logic          fire;
  logic [TW-1:0] base;
  logic          base_sat;
  logic [TW:0]   sum;
  logic [TW-1:0] total_nxt;
  logic          sat_nxt;

  assign len_ready = !out_valid_r || out_res.ready;
  assign fire      = len_valid && len_ready;

  // Add the net length, clearing first on request, stick at the top
  always_comb begin
    base      = len_clr ? '0 : total_r;
    base_sat  = len_clr ? 1'b0 : sat_r;
    sum       = {1'b0, base} + (TW + 1)'(len_value);
    total_nxt = sum[TW] ? nhpw_pkg::TOTAL_MAX : sum[TW-1:0];
    sat_nxt   = base_sat | sum[TW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      sat_r   <= 1'b0;
    end else if (fire) begin
      total_r <= total_nxt;
      sat_r   <= sat_nxt;
    end
  end

  // Result register; hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (len_ready) begin
      out_valid_r <= len_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_len_r <= len_value;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.net_length      = out_len_r;
  assign out_res.total_length    = total_r;
  assign out_res.total_saturated = sat_r;

endmodule
